### rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication on clk, held off during reset
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/sppg_pkg.sv
// package: codes, constants and divider types of the speed profile generator
package sppg_pkg;

	localparam int AXES = 2;
	localparam int FRAC_SCALE_DEF = 128;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_ACCEL = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RAMP  = 2'd1;
	localparam logic [1:0] PH_BRAKE = 2'd2;

	localparam logic [14:0] MAX_BRAKE_RESET = 15'h7fff;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

endpackage

### rtl/sppg_if.sv
// channel interfaces: command words in, result words out, register writes
interface sppg_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic               axis;
	logic signed [31:0] distance;
	logic [14:0]        brake_distance;
	logic [14:0]        top_speed;
	logic [14:0]        end_speed;
	logic [14:0]        accel;
	logic signed [15:0] align_rate;
	logic               motor_enable;

	modport source (output valid, command, axis, distance, brake_distance, top_speed,
		end_speed, accel, align_rate, motor_enable, input ready);
	modport sink (input valid, command, axis, distance, brake_distance, top_speed,
		end_speed, accel, align_rate, motor_enable, output ready);
endinterface

interface sppg_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_x;
	logic signed [15:0] speed_w;
	logic signed [11:0] feedback_x;
	logic signed [11:0] feedback_w;
	logic signed [31:0] position_x;
	logic signed [31:0] position_w;
	logic               moving_x;
	logic               moving_w;

	modport source (output valid, speed_x, speed_w, feedback_x, feedback_w, position_x,
		position_w, moving_x, moving_w, input ready);
	modport sink (input valid, speed_x, speed_w, feedback_x, feedback_w, position_x,
		position_w, moving_x, moving_w, output ready);
endinterface

interface sppg_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### rtl/two_axis_speed_profile_generator.sv
// top level: two-axis trapezoidal speed profile generator
// One command word is taken at a time and answered by one result word. Move, set-acceleration,
// stop and a tick with the motor disabled go from idle straight to the done state. An enabled
// tick runs the two axes in turn through the profile, ramp and integration states; an axis
// whose braking check needs no division also passes the apply state, and one that needs the
// braking quotient also the square and divider states, since the one shared 32-step divider
// forms (speed^2 - end^2) / (distance left - margin) there and sets the longest tick.
// Divisions by the fixed-point scale are shifts and masks, so FRAC_SCALE must be a power of
// two. The result word sits in an output register, so the next command is taken while it waits.
module two_axis_speed_profile_generator
	import sppg_pkg::*;
#(
	parameter int FRAC_SCALE = FRAC_SCALE_DEF
) (
	input logic           clk,
	input logic           arst_n,
	sppg_item_if.sink     item,
	sppg_result_if.source result,
	sppg_cfg_if.sink      cfg
);

	localparam int FRAC_SH = $clog2(FRAC_SCALE);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PROF  = 4'd1;
	localparam logic [3:0] S_SQ2   = 4'd2;
	localparam logic [3:0] S_D1    = 4'd3;
	localparam logic [3:0] S_D1W   = 4'd4;
	localparam logic [3:0] S_APPLY = 4'd5;
	localparam logic [3:0] S_RAMP  = 4'd6;
	localparam logic [3:0] S_INT   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;
	logic       ax_q;

	logic signed [31:0] pos_q  [AXES];
	logic signed [31:0] fin_q  [AXES];
	logic signed [15:0] cur_q  [AXES];
	logic signed [15:0] tgt_q  [AXES];
	logic signed [15:0] end_q  [AXES];
	logic signed [15:0] frac_q [AXES];
	logic [14:0]        acc_q  [AXES];
	logic [14:0]        mrg_q  [AXES];
	logic               fwd_q  [AXES];
	logic [1:0]         ph_q   [AXES];
	logic signed [11:0] fb_q   [AXES];

	logic [14:0]        mbd_q;
	logic signed [15:0] align_q;
	logic [31:0]        prod_q;
	logic [31:0]        num_q;
	logic [32:0]        divs_q;
	logic [31:0]        d_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	sppg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// braking check operands
	logic signed [32:0] rem_s;
	logic [32:0]        remm;
	logic signed [15:0] cs;
	logic signed [15:0] es;
	logic [15:0]        csm;
	logic [15:0]        esm;
	logic               opp;
	logic [15:0]        mul_a;
	logic [31:0]        mul_p;
	logic               at_end;
	logic               brake_due;

	assign rem_s = {fin_q[ax_q][31], fin_q[ax_q]} - {pos_q[ax_q][31], pos_q[ax_q]};
	assign remm  = rem_s[32] ? 33'(-rem_s) : rem_s;
	assign cs    = cur_q[ax_q];
	assign es    = end_q[ax_q];
	assign csm   = cs[15] ? 16'(-cs) : cs;
	assign esm   = es[15] ? 16'(-es) : es;
	assign opp   = (rem_s[32] && !cs[15]) ||
		(!rem_s[32] && rem_s != 33'sd0 && (cs[15] || cs == 16'sd0));
	assign mul_a = (state_q == S_PROF) ? csm : esm;
	assign mul_p = mul_a * mul_a;
	assign at_end = fwd_q[ax_q] ? (fin_q[ax_q] <= pos_q[ax_q]) : (fin_q[ax_q] >= pos_q[ax_q]);
	assign brake_due = d_q >= {17'd0, acc_q[ax_q]};

	// ramp
	logic signed [16:0] acc17;
	logic signed [16:0] cs17;
	logic signed [16:0] ts17;
	logic signed [16:0] up17;
	logic signed [16:0] dn17;

	assign acc17 = $signed({2'b00, acc_q[ax_q]});
	assign cs17  = {cs[15], cs};
	assign ts17  = {tgt_q[ax_q][15], tgt_q[ax_q]};
	assign up17  = cs17 + acc17;
	assign dn17  = cs17 - acc17;

	// integration
	logic signed [18:0] sum;
	logic [18:0]        summ;
	logic [18:0]        qmag;
	logic signed [15:0] extra;
	logic signed [18:0] whole;
	logic signed [19:0] fb2;
	logic [15:0]        rpart;

	assign extra = ax_q ? align_q : 16'sd0;
	assign sum   = {{3{frac_q[ax_q][15]}}, frac_q[ax_q]} + {{3{extra[15]}}, extra}
		+ {{3{cs[15]}}, cs};
	assign summ  = sum[18] ? 19'(-sum) : sum;
	assign qmag  = summ >> FRAC_SH;
	assign whole = sum[18] ? 19'(-$signed(qmag)) : $signed(qmag);
	assign fb2   = {whole, 1'b0};
	assign rpart = 16'(summ & 19'(FRAC_SCALE - 1));

	always_comb begin
		div_req = '0;
		if (state_q == S_D1) begin
			div_req.start    = 1'b1;
			div_req.dividend = num_q;
			div_req.divisor  = divs_q;
		end
	end

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q    <= 1'b0;
			mbd_q   <= MAX_BRAKE_RESET;
			align_q <= '0;
			prod_q  <= '0;
			num_q   <= '0;
			divs_q  <= '0;
			d_q     <= '0;
			result.valid <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				pos_q[a]  <= '0;
				fin_q[a]  <= '0;
				cur_q[a]  <= '0;
				tgt_q[a]  <= '0;
				end_q[a]  <= '0;
				frac_q[a] <= '0;
				acc_q[a]  <= '0;
				mrg_q[a]  <= '0;
				fwd_q[a]  <= 1'b0;
				ph_q[a]   <= PH_IDLE;
				fb_q[a]   <= '0;
			end
		end else begin
			if (cfg.valid && cfg.ready)
				mbd_q <= cfg.data;
			if (state_q == S_DONE && (!result.valid || result.ready))
				result.valid <= 1'b1;
			else if (result.valid && result.ready)
				result.valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						align_q <= item.align_rate;
						for (int a = 0; a < AXES; a++)
							fb_q[a] <= '0;
						unique case (item.command)
							CMD_TICK: begin
								if (item.motor_enable) begin
									ax_q    <= 1'b0;
									state_q <= S_PROF;
								end else begin
									state_q <= S_DONE;
									for (int a = 0; a < AXES; a++) begin
										cur_q[a] <= '0;
										tgt_q[a] <= '0;
										pos_q[a] <= '0;
										ph_q[a]  <= PH_IDLE;
									end
								end
							end
							CMD_MOVE: begin
								state_q <= S_DONE;
								if (item.distance == 32'sd0) begin
									ph_q[item.axis]  <= PH_IDLE;
									tgt_q[item.axis] <= $signed({1'b0, item.end_speed});
								end else begin
									fin_q[item.axis] <= item.distance;
									pos_q[item.axis] <= '0;
									mrg_q[item.axis] <= item.brake_distance;
									fwd_q[item.axis] <= (item.distance > 32'sd0);
									tgt_q[item.axis] <= (item.distance > 32'sd0)
										? $signed({1'b0, item.top_speed})
										: 16'(-$signed({1'b0, item.top_speed}));
									end_q[item.axis] <= (item.distance > 32'sd0)
										? $signed({1'b0, item.end_speed})
										: 16'(-$signed({1'b0, item.end_speed}));
									acc_q[item.axis] <= item.accel;
									ph_q[item.axis]  <= PH_RAMP;
								end
							end
							CMD_ACCEL: begin
								state_q <= S_DONE;
								acc_q[item.axis] <= item.accel;
							end
							CMD_STOP: begin
								state_q <= S_DONE;
								for (int a = 0; a < AXES; a++) begin
									cur_q[a] <= '0;
									tgt_q[a] <= '0;
									pos_q[a] <= '0;
									ph_q[a]  <= PH_IDLE;
								end
							end
						endcase
					end
				end
				S_PROF: begin
					if (ph_q[ax_q] == PH_IDLE) begin
						state_q <= S_RAMP;
					end else if (opp || esm >= csm) begin
						d_q     <= '0;
						state_q <= S_APPLY;
					end else if (remm <= {18'd0, mrg_q[ax_q]}) begin
						d_q     <= {17'd0, mbd_q};
						state_q <= S_APPLY;
					end else begin
						prod_q  <= mul_p;
						divs_q  <= remm - {18'd0, mrg_q[ax_q]};
						state_q <= S_SQ2;
					end
				end
				S_SQ2: begin
					num_q   <= prod_q - mul_p;
					state_q <= S_D1;
				end
				S_D1: state_q <= S_D1W;
				S_D1W: begin
					if (div_rsp.done) begin
						d_q     <= div_rsp.quot >> (FRAC_SH + 1);
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (brake_due)
						acc_q[ax_q] <= (d_q > 32'd32767) ? 15'h7fff : d_q[14:0];
					if (at_end) begin
						ph_q[ax_q]  <= PH_IDLE;
						tgt_q[ax_q] <= end_q[ax_q];
						cur_q[ax_q] <= end_q[ax_q];
					end else if (brake_due && ph_q[ax_q] == PH_RAMP) begin
						ph_q[ax_q] <= PH_BRAKE;
						if (end_q[ax_q] == 16'sd0)
							tgt_q[ax_q] <= fwd_q[ax_q]
								? $signed({1'b0, acc_q[ax_q]})
								: 16'(-$signed({1'b0, acc_q[ax_q]}));
						else
							tgt_q[ax_q] <= end_q[ax_q];
					end
					state_q <= S_RAMP;
				end
				S_RAMP: begin
					if (cs17 < ts17)
						cur_q[ax_q] <= (up17 > ts17) ? tgt_q[ax_q] : up17[15:0];
					else if (cs17 > ts17)
						cur_q[ax_q] <= (dn17 < ts17) ? tgt_q[ax_q] : dn17[15:0];
					state_q <= S_INT;
				end
				S_INT: begin
					pos_q[ax_q]  <= pos_q[ax_q] + {{13{whole[18]}}, whole};
					frac_q[ax_q] <= sum[18] ? 16'(-rpart) : rpart;
					if (fb2 > 20'sd2047)
						fb_q[ax_q] <= 12'sd2047;
					else if (fb2 < -20'sd2048)
						fb_q[ax_q] <= -12'sd2048;
					else
						fb_q[ax_q] <= fb2[11:0];
					if (ax_q) begin
						state_q <= S_DONE;
					end else begin
						ax_q    <= 1'b1;
						state_q <= S_PROF;
					end
				end
				S_DONE: begin
					if (!result.valid || result.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!result.valid || result.ready)) begin
			result.speed_x    <= cur_q[0];
			result.speed_w    <= cur_q[1];
			result.feedback_x <= fb_q[0];
			result.feedback_w <= fb_q[1];
			result.position_x <= pos_q[0];
			result.position_w <= pos_q[1];
			result.moving_x   <= (ph_q[0] != PH_IDLE);
			result.moving_w   <= (ph_q[1] != PH_IDLE);
		end
	end

endmodule

### rtl/sppg_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module sppg_divider
	import sppg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [32:0] rem_q;
	logic [31:0] quot_q;
	logic [32:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [33:0] shifted;
	logic        ge;

	assign shifted = {rem_q, quot_q[31]};
	assign ge = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? 33'(shifted - {1'b0, dvs_q}) : shifted[32:0];
			quot_q <= {quot_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### rtl/sppg_checker.sv
// port-level checker for the speed profile generator, with its bind
`include "assert_macros.svh"

module sppg_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic cfg_valid,
	input logic cfg_ready
);

	// a taken word leaves the block busy in the next cycle
	`ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready)

	// a waiting result word stays up until taken
	`ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid)

	// register writes are never stalled
	`ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind two_axis_speed_profile_generator sppg_checker u_sppg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);
